/* hw/rtl/ncs_pkg.sv */
package ncs_pkg;

   // Default capacity of the loaded solution set.
   localparam int MAX_ITEMS_DEF = 64;

   // Field widths fixed by the interface.
   localparam int OBJ_W  = 32;
   localparam int NEED_W = 7;
   localparam int IDX_W  = 6;
   localparam int DIST_W = 18;
   localparam int QUOT_W = 17;

   localparam logic [DIST_W-1:0] DIST_MAX   = 18'h3FFFF;
   localparam logic [NEED_W-1:0] SEL_RESET  = 7'd20;
   localparam logic [NEED_W-1:0] RESULT_CAP = 7'd64;

   // One quotient bit per divider step.
   localparam int DIV_STEPS = 17;

   // Depth of the result queue.
   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic              start;
      logic [NEED_W-1:0] need;
   } ctrl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } stat_type;

   typedef struct packed {
      logic             last;
      logic [IDX_W-1:0] index;
   } result_type;

endpackage

/* hw/rtl/ncs_ram.sv */
module ncs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      rdata_ff <= store_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* hw/rtl/ncs_load.sv */
module ncs_load #(
   parameter int MAX_ITEMS = ncs_pkg::MAX_ITEMS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [2*ncs_pkg::OBJ_W-1:0]         req_tdata,
   input  logic                                req_tlast,
   input  logic                                csr_we,
   input  logic [ncs_pkg::NEED_W-1:0]          csr_wdata,
   input  ncs_pkg::stat_type                   stat,
   output ncs_pkg::ctrl_type                   ctrl,
   output logic [$clog2(MAX_ITEMS+1)-1:0]      loaded,
   output logic                                wr_en,
   output logic [$clog2(MAX_ITEMS)-1:0]        wr_addr,
   output logic [ncs_pkg::OBJ_W-1:0]           wr_first,
   output logic [ncs_pkg::OBJ_W-1:0]           wr_second
);

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS+1);

   logic [CW-1:0]                 loaded_ff, loaded_in;
   logic [ncs_pkg::NEED_W-1:0]    count_ff, count_in;
   logic                          accept;

   // Requests are taken only while the back end is idle.
   assign req_tready = !stat.busy;
   assign accept     = req_tvalid && req_tready;

   // Store the objectives while there is room; extra requests are dropped.
   assign wr_en     = accept && (loaded_ff < CW'(MAX_ITEMS));
   assign wr_addr   = loaded_ff[IW-1:0];
   assign wr_first  = req_tdata[ncs_pkg::OBJ_W-1:0];
   assign wr_second = req_tdata[2*ncs_pkg::OBJ_W-1:ncs_pkg::OBJ_W];
   assign loaded    = loaded_ff;

   always_comb begin
      loaded_in = loaded_ff;
      if (stat.done) begin
         loaded_in = '0;
      end else if (wr_en) begin
         loaded_in = loaded_ff + 1'b1;
      end
      count_in = csr_we ? csr_wdata : count_ff;
   end

   // The last request of a set starts a selection run with a clamped count.
   always_comb begin
      ctrl.start = accept && req_tlast;
      if (count_ff == '0) begin
         ctrl.need = ncs_pkg::NEED_W'(1);
      end else if (count_ff > ncs_pkg::RESULT_CAP) begin
         ctrl.need = ncs_pkg::RESULT_CAP;
      end else begin
         ctrl.need = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff <= '0;
         count_ff  <= ncs_pkg::SEL_RESET;
      end else begin
         loaded_ff <= loaded_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* hw/rtl/ncs_queue.sv */
module ncs_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ncs_pkg::result_type   push_data,
   output logic                  full,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int DEPTH = ncs_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   ncs_pkg::result_type slot_ff [DEPTH];
   logic [PW-1:0]       head_ff, head_in, tail_ff, tail_in;
   logic [PW:0]         fill_ff, fill_in;
   logic                pop;

   assign full       = (fill_ff == (PW+1)'(DEPTH));
   assign rsp_tvalid = (fill_ff != '0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {{(8-ncs_pkg::IDX_W){1'b0}}, slot_ff[head_ff].index};
   assign rsp_tlast  = slot_ff[head_ff].last;

   // Pointer and fill bookkeeping.
   always_comb begin
      head_in = pop ? head_ff + 1'b1 : head_ff;
      tail_in = push ? tail_ff + 1'b1 : tail_ff;
      fill_in = fill_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[tail_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         fill_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* hw/rtl/ncs_engine.sv */
module ncs_engine #(
   parameter int MAX_ITEMS = ncs_pkg::MAX_ITEMS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ncs_pkg::ctrl_type                 ctrl,
   output ncs_pkg::stat_type                 stat,
   input  logic [$clog2(MAX_ITEMS+1)-1:0]    loaded,
   output logic [$clog2(MAX_ITEMS)-1:0]      obj_raddr,
   input  logic [ncs_pkg::OBJ_W-1:0]         obj1_rd,
   input  logic [ncs_pkg::OBJ_W-1:0]         obj2_rd,
   output logic                              q_push,
   output ncs_pkg::result_type               q_data,
   input  logic                              q_full
);

   localparam int IW   = $clog2(MAX_ITEMS);
   localparam int CW   = $clog2(MAX_ITEMS+1);
   localparam int OW   = ncs_pkg::OBJ_W;
   localparam int DW   = ncs_pkg::DIST_W;
   localparam int SEW  = OW + IW;
   localparam int SUMW = CW + ncs_pkg::NEED_W + 1;

   localparam logic [4:0] ST_IDLE  = 5'd0;
   localparam logic [4:0] ST_PSTART = 5'd1;
   localparam logic [4:0] ST_PI    = 5'd2;
   localparam logic [4:0] ST_PIW   = 5'd3;
   localparam logic [4:0] ST_PJR   = 5'd4;
   localparam logic [4:0] ST_PJC   = 5'd5;
   localparam logic [4:0] ST_EALL  = 5'd6;
   localparam logic [4:0] ST_CCLR  = 5'd7;
   localparam logic [4:0] ST_FM    = 5'd8;
   localparam logic [4:0] ST_FO    = 5'd9;
   localparam logic [4:0] ST_FW    = 5'd10;
   localparam logic [4:0] ST_SLI   = 5'd11;
   localparam logic [4:0] ST_SLIW  = 5'd12;
   localparam logic [4:0] ST_SJR   = 5'd13;
   localparam logic [4:0] ST_SJC   = 5'd14;
   localparam logic [4:0] ST_BLO   = 5'd15;
   localparam logic [4:0] ST_BLOW  = 5'd16;
   localparam logic [4:0] ST_BHIW  = 5'd17;
   localparam logic [4:0] ST_IP    = 5'd18;
   localparam logic [4:0] ST_IPW   = 5'd19;
   localparam logic [4:0] ST_INW   = 5'd20;
   localparam logic [4:0] ST_IMW   = 5'd21;
   localparam logic [4:0] ST_IDW   = 5'd22;
   localparam logic [4:0] ST_DIV   = 5'd23;
   localparam logic [4:0] ST_IWR   = 5'd24;
   localparam logic [4:0] ST_KNEXT = 5'd25;
   localparam logic [4:0] ST_SSTART = 5'd26;
   localparam logic [4:0] ST_SRD   = 5'd27;
   localparam logic [4:0] ST_SCMP  = 5'd28;
   localparam logic [4:0] ST_FIN   = 5'd29;

   logic [4:0]                   state_ff, state_in;
   logic [ncs_pkg::NEED_W-1:0]   need_ff, need_in, emitted_ff, emitted_in;
   logic [MAX_ITEMS-1:0]         taken_ff, taken_in, front_ff, front_in;
   logic [CW-1:0]                size_ff, size_in, i_ff, i_in, j_ff, j_in;
   logic                         k_ff, k_in, dom_ff, dom_in, have_ff, have_in;
   logic signed [OW-1:0]         a1_ff, a1_in, a2_ff, a2_in;
   logic [SEW-1:0]               cur_ff, cur_in;
   logic signed [OW-1:0]         lo_ff, lo_in, prev_ff, prev_in, next_ff, next_in;
   logic signed [OW:0]           range_ff, range_in;
   logic [OW+1:0]                rem_ff, rem_in;
   logic [ncs_pkg::QUOT_W-1:0]   quo_ff, quo_in;
   logic [4:0]                   cnt_ff, cnt_in;
   logic [IW-1:0]                mem_ff, mem_in, best_ff, best_in, pend_ff, pend_in;
   logic [DW-1:0]                dold_ff, dold_in, bestd_ff, bestd_in;
   logic                         pend_v_ff, pend_v_in;

   // Local memories: front member list, sorted pairs, crowding distances.
   logic          mb_we;
   logic [IW-1:0] mb_waddr, mb_raddr, mb_wdata, mb_rd;
   logic          so_we;
   logic [IW-1:0] so_waddr, so_raddr;
   logic [SEW-1:0] so_wdata, so_rd;
   logic          di_we;
   logic [IW-1:0] di_waddr, di_raddr;
   logic [DW-1:0] di_wdata, di_rd;

   // Helper terms.
   logic signed [OW-1:0] objk_rd, so_val;
   logic [IW-1:0]        so_mem;
   logic                 can_emit, emit_go, range_pos, dominates, ge;
   logic [IW-1:0]        emit_idx;
   logic [OW+1:0]        divisor, rem_sub;
   logic [DW:0]          dist_sum;
   logic [IW-1:0]        ii;

   ncs_ram #(.WIDTH(IW), .DEPTH(MAX_ITEMS)) u_members (
      .clock(clock), .we(mb_we), .waddr(mb_waddr), .wdata(mb_wdata),
      .raddr(mb_raddr), .rdata(mb_rd));

   ncs_ram #(.WIDTH(SEW), .DEPTH(MAX_ITEMS)) u_sorted (
      .clock(clock), .we(so_we), .waddr(so_waddr), .wdata(so_wdata),
      .raddr(so_raddr), .rdata(so_rd));

   ncs_ram #(.WIDTH(DW), .DEPTH(MAX_ITEMS)) u_dist (
      .clock(clock), .we(di_we), .waddr(di_waddr), .wdata(di_wdata),
      .raddr(di_raddr), .rdata(di_rd));

   assign ii        = i_ff[IW-1:0];
   assign objk_rd   = k_ff ? obj2_rd : obj1_rd;
   assign so_val    = so_rd[SEW-1:IW];
   assign so_mem    = so_rd[IW-1:0];
   assign can_emit  = !pend_v_ff || !q_full;
   assign range_pos = !range_ff[OW] && (range_ff != '0);
   assign divisor   = {1'b0, range_ff};
   assign ge        = (rem_ff >= divisor);
   assign rem_sub   = ge ? rem_ff - divisor : rem_ff;
   assign dist_sum  = {1'b0, dold_ff} + (DW+1)'(quo_ff);

   // Stored solution dominates the one held for the current peel index.
   assign dominates = ($signed(obj1_rd) <= a1_ff) && ($signed(obj2_rd) <= a2_ff)
                   && (($signed(obj1_rd) < a1_ff) || ($signed(obj2_rd) < a2_ff));

   assign stat.busy = (state_ff != ST_IDLE);

   // Sequencer: front peeling, crowding and selection.
   always_comb begin
      state_in   = state_ff;
      need_in    = need_ff;
      emitted_in = emitted_ff;
      taken_in   = taken_ff;
      front_in   = front_ff;
      size_in    = size_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      k_in       = k_ff;
      dom_in     = dom_ff;
      have_in    = have_ff;
      a1_in      = a1_ff;
      a2_in      = a2_ff;
      cur_in     = cur_ff;
      lo_in      = lo_ff;
      prev_in    = prev_ff;
      next_in    = next_ff;
      range_in   = range_ff;
      rem_in     = rem_ff;
      quo_in     = quo_ff;
      cnt_in     = cnt_ff;
      mem_in     = mem_ff;
      best_in    = best_ff;
      bestd_in   = bestd_ff;
      dold_in    = dold_ff;
      pend_in    = pend_ff;
      pend_v_in  = pend_v_ff;
      stat.done  = 1'b0;
      obj_raddr  = ii;
      mb_we      = 1'b0;
      mb_waddr   = size_ff[IW-1:0];
      mb_wdata   = ii;
      mb_raddr   = ii;
      so_we      = 1'b0;
      so_waddr   = ii;
      so_wdata   = cur_ff;
      so_raddr   = ii;
      di_we      = 1'b0;
      di_waddr   = ii;
      di_wdata   = '0;
      di_raddr   = ii;
      emit_go    = 1'b0;
      emit_idx   = ii;
      q_push     = 1'b0;
      q_data.last  = 1'b0;
      q_data.index = ncs_pkg::IDX_W'(pend_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (ctrl.start) begin
               need_in    = ctrl.need;
               emitted_in = '0;
               taken_in   = '0;
               front_in   = '0;
               pend_v_in  = 1'b0;
               state_in   = ST_PSTART;
            end
         end
         ST_PSTART: begin
            i_in    = '0;
            size_in = '0;
            state_in = (emitted_ff >= need_ff) ? ST_FIN : ST_PI;
         end
         ST_PI: begin
            if (i_ff == loaded) begin
               i_in = '0;
               if (size_ff == '0) begin
                  state_in = ST_FIN;
               end else if (SUMW'(emitted_ff) + SUMW'(size_ff) > SUMW'(need_ff)) begin
                  state_in = ST_CCLR;
               end else begin
                  state_in = ST_EALL;
               end
            end else if (taken_ff[ii]) begin
               front_in[ii] = 1'b0;
               i_in = i_ff + 1'b1;
            end else begin
               state_in = ST_PIW;
            end
         end
         ST_PIW: begin
            a1_in    = $signed(obj1_rd);
            a2_in    = $signed(obj2_rd);
            j_in     = '0;
            dom_in   = 1'b0;
            state_in = ST_PJR;
         end
         ST_PJR: begin
            obj_raddr = j_ff[IW-1:0];
            if (dom_ff || j_ff == loaded) begin
               front_in[ii] = !dom_ff;
               if (!dom_ff) begin
                  mb_we   = 1'b1;
                  size_in = size_ff + 1'b1;
               end
               i_in     = i_ff + 1'b1;
               state_in = ST_PI;
            end else if (j_ff == i_ff || taken_ff[j_ff[IW-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = ST_PJC;
            end
         end
         ST_PJC: begin
            dom_in   = dominates;
            j_in     = j_ff + 1'b1;
            state_in = ST_PJR;
         end
         // The whole front fits: emit it in index order.
         ST_EALL: begin
            if (i_ff == loaded) begin
               state_in = ST_PSTART;
            end else if (front_ff[ii]) begin
               if (can_emit) begin
                  emit_go      = 1'b1;
                  taken_in[ii] = 1'b1;
                  i_in         = i_ff + 1'b1;
               end
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_CCLR: begin
            if (i_ff == loaded) begin
               i_in     = '0;
               k_in     = 1'b0;
               state_in = ST_FM;
            end else begin
               di_we = front_ff[ii];
               i_in  = i_ff + 1'b1;
            end
         end
         // Copy (objective, member) pairs into the sort memory.
         ST_FM: begin
            if (i_ff == size_ff) begin
               i_in     = '0;
               state_in = ST_SLI;
            end else begin
               state_in = ST_FO;
            end
         end
         ST_FO: begin
            obj_raddr = mb_rd;
            mem_in    = mb_rd;
            state_in  = ST_FW;
         end
         ST_FW: begin
            so_we    = 1'b1;
            so_wdata = {objk_rd, mem_ff};
            i_in     = i_ff + 1'b1;
            state_in = ST_FM;
         end
         // Exchange sort: position i holds the running minimum over j.
         ST_SLI: begin
            state_in = ((CW+1)'(i_ff) + 1'b1 >= (CW+1)'(size_ff)) ? ST_BLO : ST_SLIW;
         end
         ST_SLIW: begin
            cur_in   = so_rd;
            j_in     = i_ff + 1'b1;
            state_in = ST_SJR;
         end
         ST_SJR: begin
            so_raddr = j_ff[IW-1:0];
            if (j_ff == size_ff) begin
               so_we    = 1'b1;
               i_in     = i_ff + 1'b1;
               state_in = ST_SLI;
            end else begin
               state_in = ST_SJC;
            end
         end
         ST_SJC: begin
            if ($signed(cur_ff[SEW-1:IW]) > so_val) begin
               so_we    = 1'b1;
               so_waddr = j_ff[IW-1:0];
               cur_in   = so_rd;
            end
            j_in     = j_ff + 1'b1;
            state_in = ST_SJR;
         end
         // Boundary members of the sorted order get the maximum distance.
         ST_BLO: begin
            so_raddr = '0;
            state_in = ST_BLOW;
         end
         ST_BLOW: begin
            di_we    = 1'b1;
            di_waddr = so_mem;
            di_wdata = ncs_pkg::DIST_MAX;
            lo_in    = so_val;
            so_raddr = IW'(size_ff - 1'b1);
            state_in = ST_BHIW;
         end
         ST_BHIW: begin
            di_we    = 1'b1;
            di_waddr = so_mem;
            di_wdata = ncs_pkg::DIST_MAX;
            range_in = {so_val[OW-1], so_val} - {lo_ff[OW-1], lo_ff};
            i_in     = CW'(1);
            state_in = ST_IP;
         end
         // Interior members add the normalized neighbor gap.
         ST_IP: begin
            so_raddr = IW'(i_ff - 1'b1);
            if (((CW+1)'(i_ff) + 1'b1 >= (CW+1)'(size_ff)) || !range_pos) begin
               state_in = ST_KNEXT;
            end else begin
               state_in = ST_IPW;
            end
         end
         ST_IPW: begin
            prev_in  = so_val;
            so_raddr = IW'(i_ff + 1'b1);
            state_in = ST_INW;
         end
         ST_INW: begin
            next_in  = so_val;
            state_in = ST_IMW;
         end
         ST_IMW: begin
            mem_in   = so_mem;
            di_raddr = so_mem;
            state_in = ST_IDW;
         end
         ST_IDW: begin
            dold_in  = di_rd;
            rem_in   = (OW+2)'({next_ff[OW-1], next_ff} - {prev_ff[OW-1], prev_ff});
            quo_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            quo_in = {quo_ff[ncs_pkg::QUOT_W-2:0], ge};
            rem_in = {rem_sub[OW:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 5'(ncs_pkg::DIV_STEPS - 1)) begin
               state_in = ST_IWR;
            end
         end
         ST_IWR: begin
            di_we    = 1'b1;
            di_waddr = mem_ff;
            di_wdata = (dist_sum > (DW+1)'(ncs_pkg::DIST_MAX)) ? ncs_pkg::DIST_MAX
                                                              : dist_sum[DW-1:0];
            i_in     = i_ff + 1'b1;
            state_in = ST_IP;
         end
         ST_KNEXT: begin
            i_in = '0;
            if (k_ff) begin
               state_in = ST_SSTART;
            end else begin
               k_in     = 1'b1;
               state_in = ST_FM;
            end
         end
         // Pick the largest distance, earliest member on a tie.
         ST_SSTART: begin
            i_in     = '0;
            have_in  = 1'b0;
            state_in = (emitted_ff >= need_ff) ? ST_FIN : ST_SRD;
         end
         ST_SRD: begin
            if (i_ff == loaded) begin
               if (!have_ff) begin
                  state_in = ST_FIN;
               end else if (can_emit) begin
                  emit_go            = 1'b1;
                  emit_idx           = best_ff;
                  front_in[best_ff]  = 1'b0;
                  taken_in[best_ff]  = 1'b1;
                  state_in           = ST_SSTART;
               end
            end else if (front_ff[ii]) begin
               state_in = ST_SCMP;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         ST_SCMP: begin
            if (!have_ff || di_rd > bestd_ff) begin
               best_in  = ii;
               bestd_in = di_rd;
               have_in  = 1'b1;
            end
            i_in     = i_ff + 1'b1;
            state_in = ST_SRD;
         end
         ST_FIN: begin
            if (!pend_v_ff || !q_full) begin
               q_push      = pend_v_ff;
               q_data.last = 1'b1;
               pend_v_in   = 1'b0;
               taken_in    = '0;
               front_in    = '0;
               stat.done   = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // The previous pick is released once the next one is known.
      if (emit_go) begin
         q_push     = pend_v_ff;
         pend_in    = emit_idx;
         pend_v_in  = 1'b1;
         emitted_in = emitted_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         emitted_ff <= '0;
         taken_ff   <= '0;
         front_ff   <= '0;
         pend_v_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         emitted_ff <= emitted_in;
         taken_ff   <= taken_in;
         front_ff   <= front_in;
         pend_v_ff  <= pend_v_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff  <= need_in;
      size_ff  <= size_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      k_ff     <= k_in;
      dom_ff   <= dom_in;
      have_ff  <= have_in;
      a1_ff    <= a1_in;
      a2_ff    <= a2_in;
      cur_ff   <= cur_in;
      lo_ff    <= lo_in;
      prev_ff  <= prev_in;
      next_ff  <= next_in;
      range_ff <= range_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      cnt_ff   <= cnt_in;
      mem_ff   <= mem_in;
      best_ff  <= best_in;
      bestd_ff <= bestd_in;
      dold_ff  <= dold_in;
      pend_ff  <= pend_in;
   end

   // A result is never pushed into a full queue.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full) else $error("result pushed into full queue");

   // A run never emits more indices than were asked for.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> (emitted_ff <= need_ff))
      else $error("emitted count above requested count");

   // The final result of a run returns the sequencer to idle.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      (q_push && q_data.last) |=> (state_ff == ST_IDLE))
      else $error("run continued after final result");

   // Only current front members are compared during selection.
   a_select_front: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCMP) |-> front_ff[ii])
      else $error("selection compared a non-member");

endmodule

/* hw/rtl/nondominated_crowding_select_top.sv */
// Selects solution indices from a loaded set of two-objective solutions by
// non-dominated sorting with crowding distance. Each request loads one
// solution (both objectives signed Q16.16, smaller is better); the request
// marked tlast starts selection, and no request is taken until the run has
// finished. A run peels fronts from the untaken solutions, each peel
// comparing every untaken solution with the other untaken ones until one
// dominates it, then crowds the overflowing front with an exchange sort per
// objective and a divide with a 17-bit quotient per interior member, and
// finally picks members by largest distance. Each store has a single read
// port. Results leave through a four-entry queue with the index in
// rsp_tdata and tlast on the final index of the run.
module nondominated_crowding_select_top #(
   parameter int MAX_ITEMS = ncs_pkg::MAX_ITEMS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [63:0]                 req_tdata,   // obj_first [31:0], obj_second [63:32]
   input  logic                        req_tlast,   // last_item
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [7:0]                  rsp_tdata,   // chosen_index [5:0], zero [7:6]
   output logic                        rsp_tlast,   // last_result
   input  logic                        csr_we,
   input  logic [6:0]                  csr_wdata    // select_count
);

   localparam int IW = $clog2(MAX_ITEMS);
   localparam int CW = $clog2(MAX_ITEMS+1);

   ncs_pkg::ctrl_type             ctrl;
   ncs_pkg::stat_type             stat;
   ncs_pkg::result_type           q_data;
   logic [CW-1:0]                 loaded;
   logic                          wr_en, q_push, q_full;
   logic [IW-1:0]                 wr_addr, obj_raddr;
   logic [ncs_pkg::OBJ_W-1:0]     wr_first, wr_second, obj1_rd, obj2_rd;

   // Front end: takes requests and stores objectives.
   ncs_load #(.MAX_ITEMS(MAX_ITEMS)) u_load (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .stat(stat), .ctrl(ctrl), .loaded(loaded),
      .wr_en(wr_en), .wr_addr(wr_addr), .wr_first(wr_first), .wr_second(wr_second));

   // Objective stores shared between loader and sequencer.
   ncs_ram #(.WIDTH(ncs_pkg::OBJ_W), .DEPTH(MAX_ITEMS)) u_first (
      .clock(clock), .we(wr_en), .waddr(wr_addr), .wdata(wr_first),
      .raddr(obj_raddr), .rdata(obj1_rd));

   ncs_ram #(.WIDTH(ncs_pkg::OBJ_W), .DEPTH(MAX_ITEMS)) u_second (
      .clock(clock), .we(wr_en), .waddr(wr_addr), .wdata(wr_second),
      .raddr(obj_raddr), .rdata(obj2_rd));

   // Back end: peeling, crowding and selection.
   ncs_engine #(.MAX_ITEMS(MAX_ITEMS)) u_engine (
      .clock(clock), .reset(reset), .ctrl(ctrl), .stat(stat), .loaded(loaded),
      .obj_raddr(obj_raddr), .obj1_rd(obj1_rd), .obj2_rd(obj2_rd),
      .q_push(q_push), .q_data(q_data), .q_full(q_full));

   // Result queue toward the response channel.
   ncs_queue u_queue (
      .clock(clock), .reset(reset), .push(q_push), .push_data(q_data),
      .full(q_full), .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast));

endmodule
